// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define AM_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk and switched off during rst.
`define AM_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/i2p_pkg.sv =====
// Package of types, character constants and decode functions for the converter.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Characters with a special meaning.
  localparam logic [7:0] CH_LPAR  = 8'h28;  // (
  localparam logic [7:0] CH_RPAR  = 8'h29;  // )
  localparam logic [7:0] CH_POW   = 8'h5E;  // ^
  localparam logic [7:0] CH_MUL   = 8'h2A;  // *
  localparam logic [7:0] CH_DIV   = 8'h2F;  // /
  localparam logic [7:0] CH_MOD   = 8'h25;  // %
  localparam logic [7:0] CH_ADD   = 8'h2B;  // +
  localparam logic [7:0] CH_SUB   = 8'h2D;  // -

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_PAREN    = 2'd2,
    ERR_UNKNOWN  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_ALNUM,
    CLS_LPAR,
    CLS_RPAR,
    CLS_OPER,
    CLS_UNKNOWN
  } cls_t;

  // Source of an emitted result.
  typedef enum logic [1:0] {
    SRC_CHAR,
    SRC_TOP,
    SRC_ERR,
    SRC_MARK
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH,
    ST_CL_TEST,
    ST_CL_CHK,
    ST_OP_TEST,
    ST_OP_CHK,
    ST_FL_TEST,
    ST_FL_CHK,
    ST_TAIL,
    ST_MARK,
    ST_FIN
  } state_t;

  // One result item.
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       done;
    err_t       err;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic rd_top;
    logic push;
    logic pop;
    logic emit;
    src_t src;
    logic set_err;
    err_t err_code;
    logic finish;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cls_t cls;
    logic last;
    logic count_zero;
    logic full;
    logic err_set;
    logic top_lpar;
    logic top_pops;
    logic out_free;
    logic pend_valid;
  } sts_t;

  // Operator precedence; zero for anything that is not an operator.
  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    case (c)
      CH_POW:                 p = 2'd3;
      CH_MUL, CH_DIV, CH_MOD: p = 2'd2;
      CH_ADD, CH_SUB:         p = 2'd1;
      default:                p = 2'd0;
    endcase
    return p;
  endfunction

  // Character class of one input character.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    k = CLS_UNKNOWN;
    case (c) inside
      [8'h09:8'h0D], 8'h20:                     k = CLS_SPACE;
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: k = CLS_ALNUM;
      CH_LPAR:                                  k = CLS_LPAR;
      CH_RPAR:                                  k = CLS_RPAR;
      CH_POW, CH_MUL, CH_DIV, CH_MOD, CH_ADD, CH_SUB: k = CLS_OPER;
      default:                                  k = CLS_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2p_dpath.sv =====
// Datapath of the converter: operator stack memory, counters, error latch and result registers.
`timescale 1ns / 1ps
`default_nettype none

module i2p_dpath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire i2p_pkg::cmd_t cmd,
  output i2p_pkg::sts_t      sts,
  input  wire logic [7:0]    in_char,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output i2p_pkg::res_t      out_res,
  output logic               out_last
);
  import i2p_pkg::*;

  logic [7:0]        mem [STACK_DEPTH];
  logic [7:0]        cur;
  logic              last;
  logic [CNT_W-1:0]  count;
  err_t              err_q;
  logic [7:0]        rd_data;
  logic              pend_valid;
  res_t              pend;
  res_t              new_res;
  logic [CNT_W-1:0]  count_dec;
  logic [1:0]        p_top;
  logic [1:0]        p_cur;
  logic              move;

  assign count_dec = count - CNT_W'(1);

  // Captured input request.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur  <= in_char;
      last <= in_last;
    end
  end

  // Stack memory: one write port at the fill level, one registered read of the top.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[ADDR_W-1:0]] <= cur;
    end
    if (cmd.rd_top) begin
      rd_data <= mem[count_dec[ADDR_W-1:0]];
    end
  end

  // Fill level and error latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err_q <= ERR_NONE;
    end else if (cmd.clear) begin
      count <= '0;
      err_q <= ERR_NONE;
    end else begin
      if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count_dec;
      end
      if (cmd.set_err) begin
        err_q <= cmd.err_code;
      end
    end
  end

  // Result selection.
  always_comb begin
    new_res = '0;
    unique case (cmd.src)
      SRC_CHAR: begin
        new_res.ch    = cur;
        new_res.valid = 1'b1;
        new_res.err   = err_q;
      end
      SRC_TOP: begin
        new_res.ch    = rd_data;
        new_res.valid = 1'b1;
        new_res.err   = err_q;
      end
      SRC_ERR: begin
        new_res.err = cmd.err_code;
      end
      SRC_MARK: begin
        new_res.done = 1'b1;
        new_res.err  = err_q;
      end
      default: new_res = '0;
    endcase
  end

  // A result waits in the pending slot until the next one or the end of the
  // request shows whether it is the last of its run.
  assign move = (cmd.emit && pend_valid) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.finish) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend <= new_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res  <= pend;
      out_last <= cmd.finish;
    end
  end

  // Status toward the controller.
  assign p_top = prec(rd_data);
  assign p_cur = prec(cur);

  always_comb begin
    sts            = '0;
    sts.cls        = classify(cur);
    sts.last       = last;
    sts.count_zero = (count == '0);
    sts.full       = (count >= CNT_W'(STACK_DEPTH));
    sts.err_set    = (err_q != ERR_NONE);
    sts.top_lpar   = (rd_data == CH_LPAR);
    sts.top_pops   = (p_top > p_cur) || ((p_top == p_cur) && (cur != CH_POW));
    sts.out_free   = !out_valid || out_ready;
    sts.pend_valid = pend_valid;
  end

endmodule

`default_nettype wire

// ===== rtl/i2p_ctrl.sv =====
// Controller state machine of the converter: sequences decode, stack walks, flush and result release.
`timescale 1ns / 1ps
`default_nettype none

module i2p_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire i2p_pkg::sts_t sts,
  output i2p_pkg::cmd_t      cmd
);
  import i2p_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    cmd.src    = SRC_CHAR;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.err_set) begin
          state_next = sts.last ? ST_MARK : ST_IDLE;
        end else begin
          unique case (sts.cls)
            CLS_SPACE: state_next = ST_TAIL;
            CLS_ALNUM: begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.src    = SRC_CHAR;
                state_next = ST_TAIL;
              end
            end
            CLS_LPAR: state_next = ST_PUSH;
            CLS_RPAR: state_next = ST_CL_TEST;
            CLS_OPER: state_next = ST_OP_TEST;
            default: begin
              if (sts.out_free) begin
                cmd.emit     = 1'b1;
                cmd.src      = SRC_ERR;
                cmd.set_err  = 1'b1;
                cmd.err_code = ERR_UNKNOWN;
                state_next   = ST_TAIL;
              end
            end
          endcase
        end
      end
      ST_PUSH: begin
        if (!sts.full) begin
          cmd.push   = 1'b1;
          state_next = ST_TAIL;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_ERR;
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_OVERFLOW;
          state_next   = ST_TAIL;
        end
      end
      // Closing parenthesis: pop and emit down to the matching open one.
      ST_CL_TEST: begin
        if (!sts.count_zero) begin
          cmd.rd_top = 1'b1;
          state_next = ST_CL_CHK;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_ERR;
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_PAREN;
          state_next   = ST_TAIL;
        end
      end
      ST_CL_CHK: begin
        if (sts.top_lpar) begin
          cmd.pop    = 1'b1;
          state_next = ST_TAIL;
        end else if (sts.out_free) begin
          cmd.pop    = 1'b1;
          cmd.emit   = 1'b1;
          cmd.src    = SRC_TOP;
          state_next = ST_CL_TEST;
        end
      end
      // Operator: pop operators that bind tighter or as tight ('^' groups to the right), then push.
      ST_OP_TEST: begin
        if (sts.count_zero) begin
          state_next = ST_PUSH;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = ST_OP_CHK;
        end
      end
      ST_OP_CHK: begin
        if (sts.top_lpar || !sts.top_pops) begin
          state_next = ST_PUSH;
        end else if (sts.out_free) begin
          cmd.pop    = 1'b1;
          cmd.emit   = 1'b1;
          cmd.src    = SRC_TOP;
          state_next = ST_OP_TEST;
        end
      end
      // End of expression: empty the stack.
      ST_FL_TEST: begin
        if (sts.count_zero) begin
          state_next = ST_MARK;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = ST_FL_CHK;
        end
      end
      ST_FL_CHK: begin
        if (sts.top_lpar) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ERR_PAREN;
          state_next   = ST_MARK;
        end else if (sts.out_free) begin
          cmd.pop    = 1'b1;
          cmd.emit   = 1'b1;
          cmd.src    = SRC_TOP;
          state_next = ST_FL_TEST;
        end
      end
      ST_TAIL: begin
        if (!sts.last) begin
          state_next = ST_FIN;
        end else if (sts.err_set) begin
          state_next = ST_MARK;
        end else begin
          state_next = ST_FL_TEST;
        end
      end
      ST_MARK: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_MARK;
          cmd.clear  = 1'b1;
          state_next = ST_FIN;
        end
      end
      // Release the held result as the last one of this request.
      ST_FIN: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/infix_to_postfix_converter.sv =====
// Shunting-yard infix to postfix converter, one character per input request. A letter,
// digit, whitespace or unknown character passes through accept, decode, wrap-up and
// release, and a '(' adds a push step. A ')' reads and pops stack entries down to the
// matching '(', or flags an error when it finds the stack empty. An operator pops the
// entries that bind tighter or as tight ('^' groups to the right), checks the entry that
// stops it unless the stack is empty, and pushes. The stack memory has a single read port
// with a registered read of the top, so each checked entry takes a read step and a check
// step. At the end of an expression the flush pops entries until the stack is empty or an
// unmatched '(' latches an error, then emits the marker; with an error latched it skips
// the flush. While an error is latched, a request without end_of_expr is dropped. One
// result is held in a pending slot until the next one shows whether it closes its run,
// and each new result waits while the output register still holds one that has not been
// taken. The stack holds STACK_DEPTH entries; its memory is not cleared and needs no
// start-up pass.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic       s_axis_tlast,   // end_of_expr
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic            m_axis_tlast,   // run_last
  output logic [3:0]      m_axis_tuser    // [0] char_valid, [1] expr_done, [3:2] error_code
);
  import i2p_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t out_res;

  // Controller.
  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  i2p_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_char   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .out_last  (m_axis_tlast)
  );

  // Result fields onto the output stream.
  assign m_axis_tdata = out_res.ch;
  assign m_axis_tuser = {out_res.err, out_res.done, out_res.valid};

endmodule

`default_nettype wire

// ===== rtl/i2p_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i2p_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic [3:0] m_axis_tuser
);

  // A stalled result request stays offered.
  `AM_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // The end-of-expression marker closes its run and carries no character.
  `AM_IMPLY(a_done_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && !m_axis_tuser[0])

  // Characters come out only while no error is latched.
  `AM_IMPLY(a_char_clean, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[3:2] == 2'd0)

  // Results without a character carry a zero byte.
  `AM_IMPLY(a_zero_data, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)

endmodule

bind infix_to_postfix_converter i2p_checker u_checker (.*);

`default_nettype wire

// ===== test/infix_to_postfix_converter_tb.sv =====
// Self-checking testbench for the infix to postfix converter with its own shunting-yard predictor.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  // Cycles the receiver holds off in one stretch, and the request count that starts it.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 40;
  // Cycles allowed after the last expected result for stray output.
  localparam int TAIL_CYCLES = 150;
  localparam int RANDOM_ITEMS = 350;

  // One infix character as queued for the sender.
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         drain;
  } infix_item_t;

  // One postfix result, field by field.
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       run_end;
    logic       done;
    err_t       err;
  } postfix_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [3:0] m_axis_tuser;

  infix_item_t infix_q[$];
  postfix_t    postfix_q[$];
  int          total_items;
  int          taken_cnt = 0;
  int          mismatch_cnt = 0;
  bit          drain_next = 1'b0;
  logic        hold_req = 1'b0;

  // Predictor state: operator stack, its fill level and the latched error.
  logic [7:0]  op_stack [STACK_DEPTH];
  int unsigned depth_used = 0;
  err_t        err_held = ERR_NONE;

  infix_to_postfix_converter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Operator binding strength; zero for anything that is not an operator.
  function automatic int unsigned rank_of(logic [7:0] c);
    case (c)
      CH_POW:                 return 3;
      CH_MUL, CH_DIV, CH_MOD: return 2;
      CH_ADD, CH_SUB:         return 1;
      default:                return 0;
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_operand(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Queue one expected result; the error field reflects the latch at this point.
  function automatic void emit_expect(logic [7:0] ch, logic ok, logic done);
    postfix_t r;
    r.ch      = ch;
    r.valid   = ok;
    r.run_end = 1'b0;
    r.done    = done;
    r.err     = err_held;
    postfix_q.push_back(r);
  endfunction

  // Work out every result that one accepted character causes.
  task automatic predict_postfix(input logic [7:0] c, input logic fin);
    int unsigned first;
    logic [7:0]  top;
    bit          stop;
    first = postfix_q.size();
    if (err_held == ERR_NONE) begin
      if (is_blank(c)) begin
        // Whitespace is dropped.
      end else if (is_operand(c)) begin
        emit_expect(c, 1'b1, 1'b0);
      end else if (c == CH_RPAR) begin
        // Pop down to the matching open parenthesis, which is dropped.
        stop = 1'b0;
        while (!stop) begin
          if (depth_used == 0) begin
            err_held = ERR_PAREN;
            emit_expect(8'h00, 1'b0, 1'b0);
            stop = 1'b1;
          end else begin
            depth_used--;
            top = op_stack[depth_used];
            if (top == CH_LPAR) stop = 1'b1;
            else emit_expect(top, 1'b1, 1'b0);
          end
        end
      end else if (c == CH_LPAR || rank_of(c) != 0) begin
        // Operators first pop what binds tighter or as tight; '^' groups to the right.
        stop = (c == CH_LPAR);
        while (depth_used > 0 && !stop) begin
          top = op_stack[depth_used - 1];
          if (top != CH_LPAR && (rank_of(top) > rank_of(c) ||
              (rank_of(top) == rank_of(c) && c != CH_POW))) begin
            depth_used--;
            emit_expect(top, 1'b1, 1'b0);
          end else begin
            stop = 1'b1;
          end
        end
        if (depth_used >= STACK_DEPTH) begin
          err_held = ERR_OVERFLOW;
          emit_expect(8'h00, 1'b0, 1'b0);
        end else begin
          op_stack[depth_used] = c;
          depth_used++;
        end
      end else begin
        err_held = ERR_UNKNOWN;
        emit_expect(8'h00, 1'b0, 1'b0);
      end
    end
    // End of expression: flush unless an error is latched, then the closing marker.
    if (fin) begin
      stop = (err_held != ERR_NONE);
      while (depth_used > 0 && !stop) begin
        depth_used--;
        top = op_stack[depth_used];
        if (top == CH_LPAR) begin
          err_held = ERR_PAREN;
          stop = 1'b1;
        end else begin
          emit_expect(top, 1'b1, 1'b0);
        end
      end
      emit_expect(8'h00, 1'b0, 1'b1);
      depth_used = 0;
      err_held = ERR_NONE;
    end
    if (postfix_q.size() > first) postfix_q[postfix_q.size() - 1].run_end = 1'b1;
  endtask

  // Stimulus building helpers.
  function automatic void queue_char(logic [7:0] c, logic fin);
    infix_item_t it;
    it.ch    = c;
    it.fin   = fin;
    it.drain = drain_next;
    drain_next = 1'b0;
    infix_q.push_back(it);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endfunction

  function automatic void end_expr();
    infix_q[infix_q.size() - 1].fin = 1'b1;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 5))
      0:       return CH_POW;
      1:       return CH_MUL;
      2:       return CH_DIV;
      3:       return CH_MOD;
      4:       return CH_ADD;
      default: return CH_SUB;
    endcase
  endfunction

  function automatic void queue_operand();
    if ($urandom_range(0, 5) == 0)
      queue_char(($urandom_range(0, 3) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4)), 1'b0);
    case ($urandom_range(0, 2))
      0:       queue_char(8'("a" + $urandom_range(0, 25)), 1'b0);
      1:       queue_char(8'("A" + $urandom_range(0, 25)), 1'b0);
      default: queue_char(8'("0" + $urandom_range(0, 9)), 1'b0);
    endcase
  endfunction

  // Random well-formed expression, nested up to lvl levels.
  task automatic queue_expr(input int lvl);
    int k;
    k = $urandom_range(0, 3);
    if (lvl == 0 || k == 0) begin
      queue_operand();
    end else if (k == 1) begin
      queue_char(CH_LPAR, 1'b0);
      queue_expr(lvl - 1);
      queue_char(CH_RPAR, 1'b0);
    end else begin
      queue_expr(lvl - 1);
      queue_char(pick_op(), 1'b0);
      queue_expr(lvl - 1);
    end
  endtask

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_cnt++;
      $display("%0t ns: %s expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : send_proc
    infix_item_t it;
    bit          slot_free;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_postfix(s_axis_tdata, s_axis_tlast);
        taken_cnt++;
        if (taken_cnt == HOLD_AT) hold_req <= 1'b1;
      end
      slot_free = !s_axis_tvalid || s_axis_tready;
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (infix_q.size() > 0 && !(infix_q[0].drain && postfix_q.size() > 0)) begin
          it = infix_q.pop_front();
          s_axis_tdata  <= it.ch;
          s_axis_tlast  <= it.fin;
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
  int  mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_seen = 1'b0;

  always @(posedge clk) begin : recv_proc
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : watch_proc
    postfix_t want;
    postfix_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ch      = m_axis_tdata;
      got.valid   = m_axis_tuser[0];
      got.run_end = m_axis_tlast;
      got.done    = m_axis_tuser[1];
      got.err     = err_t'(m_axis_tuser[3:2]);
      if (postfix_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t ns: result with none expected, got data %0h last %b user %0h",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = postfix_q.pop_front();
        check_field("out_char", want.ch, got.ch);
        check_field("char_valid", want.valid, got.valid);
        check_field("run_last", want.run_end, got.run_end);
        check_field("expr_done", want.done, got.done);
        check_field("error_code", want.err, got.err);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_ctl
    int n_directed;
    int sel;
    int n;
    int expr_no;

    // Directed: every operator, precedence and grouping, and the unknown-character and parenthesis errors.
    queue_text("a/b+c%d");
    queue_text("(Z-0)*x^y^9");
    queue_text("\t)");
    queue_text("(");
    queue_char(8'h7B, 1'b1);
    queue_char(8'h00, 1'b1);
    queue_char(8'hFF, 1'b0);
    queue_char("a", 1'b1);
    n_directed = infix_q.size();

    // Random part; the sender first waits for the directed results to drain.
    drain_next = 1'b1;
    expr_no = 0;
    while (infix_q.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) drain_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (expr_no == 3) begin
        // Open parentheses beyond the stack depth.
        for (int i = 0; i < STACK_DEPTH + 1; i++) queue_char(CH_LPAR, 1'b0);
        queue_operand();
        end_expr();
      end else if (expr_no == 6) begin
        // Right-grouping chain that fills the stack exactly, then one long flush.
        queue_operand();
        for (int i = 0; i < STACK_DEPTH; i++) begin
          queue_char(CH_POW, 1'b0);
          queue_operand();
        end
        end_expr();
      end else if (sel < 65) begin
        queue_expr($urandom_range(0, 3));
        end_expr();
      end else if (sel < 69) begin
        n = $urandom_range(5, STACK_DEPTH + 1);
        for (int i = 0; i < n; i++) queue_char(CH_LPAR, 1'b0);
        queue_operand();
        for (int i = 0; i < n; i++) queue_char(CH_RPAR, 1'b0);
        end_expr();
      end else if (sel < 85) begin
        // Broken expression: stray parenthesis or an arbitrary byte inside.
        n = $urandom_range(0, 2);
        if (n == 0) queue_char(CH_LPAR, 1'b0);
        queue_expr($urandom_range(0, 2));
        if (n == 1) queue_char(CH_RPAR, 1'b0);
        if (n == 2) begin
          queue_char(8'($urandom_range(0, 255)), 1'b0);
          queue_operand();
        end
        end_expr();
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          queue_char(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
        end_expr();
      end
      expr_no++;
    end
    total_items = infix_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (taken_cnt < total_items || postfix_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("%0t ns: timeout with %0d requests unsent and %0d results outstanding",
             $time, infix_q.size(), postfix_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
